// File: rtl/tcce_pkg.sv
// types and constants shared by the text console character engine
package tcce_pkg;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h0F;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } out_item_t;

endpackage

// File: rtl/text_console_char_engine_top.sv
// text console character engine: screen store, cursor and scroll/clear sequencer
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------
//  input   | start / busy               | in_data   (mode, char, index)
//  result  | out_valid, one-cycle pulse | out_data  (entry, cursor, scroll)
//  config  | cfg_valid / cfg_ready      | cfg_data  (text color)
//
// newline without scroll, unused mode or out-of-range read answer straight from exec;
// put character passes the put state and an in-range read the read-out state; clear
// sweeps the store to spaces and a scroll moves rows up then blanks the bottom line,
// all on the one store port and address counter; reset sweeps it to spaces, busy high.
// a new item is taken in the cycle that shows the previous result.
// the receiver cannot stall; config writes are always taken.
module text_console_char_engine_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tcce_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output tcce_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int TOP   = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int XW    = (AW > 11) ? AW : 11;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_PUT    = 3'd2;
  localparam logic [2:0] S_RDOUT  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;

  logic [15:0] mem [CELLS];
  logic [15:0] rd_data_r;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          scr_r, scr_nxt;
  logic          init_r, init_nxt;
  logic [15:0]   fill_r, fill_nxt;
  logic [7:0]    color_r, color_nxt;
  in_item_t      item_r, item_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;
  logic [15:0]   entry;
  logic [XW-1:0] idx_ext;
  logic          idx_ok;
  logic          last_row;

  assign idx_ext  = XW'(item_r.cell_index);
  assign idx_ok   = idx_ext < XW'(CELLS);
  assign last_row = row_r == RW'(ROWS - 1);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    scr_nxt       = scr_r;
    init_nxt      = init_r;
    fill_nxt      = fill_r;
    item_nxt      = item_r;
    color_nxt     = color_r;
    out_valid_nxt = 1'b0;
    entry         = 16'd0;
    mem_we        = 1'b0;
    mem_wa        = k_r;
    mem_wd        = fill_r;
    mem_ra        = AW'(idx_ext);

    if (cfg_valid) begin
      color_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          scr_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_r.mode)
          MODE_PUT: begin
            if (item_r.char_code == NEWLINE_CODE) begin
              col_nxt = '0;
              if (last_row) begin
                scr_nxt   = 1'b1;
                k_nxt     = '0;
                state_nxt = S_SCROLL;
              end else begin
                row_nxt       = row_r + 1'b1;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
            end else begin
              addr_nxt  = AW'(AW'(row_r) * AW'(COLUMNS)) + AW'(col_r);
              state_nxt = S_PUT;
            end
          end
          MODE_CLEAR: begin
            k_nxt     = '0;
            fill_nxt  = {color_r, SPACE_CODE};
            row_nxt   = '0;
            col_nxt   = '0;
            state_nxt = S_FILL;
          end
          MODE_READ: begin
            if (idx_ok) begin
              state_nxt = S_RDOUT;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = addr_r;
        mem_wd = {color_r, item_r.char_code};
        if (col_r == CW'(COLUMNS - 1)) begin
          col_nxt = '0;
          if (last_row) begin
            scr_nxt   = 1'b1;
            k_nxt     = '0;
            state_nxt = S_SCROLL;
          end else begin
            row_nxt       = row_r + 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          col_nxt       = col_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RDOUT: begin
        entry         = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCROLL: begin
        // read one row below, write the previous read one cell behind
        mem_ra = (k_r < AW'(TOP)) ? AW'(k_r + AW'(COLUMNS)) : '0;
        mem_we = k_r != '0;
        mem_wa = k_r - 1'b1;
        mem_wd = {color_r, rd_data_r[7:0]};
        if (k_r == AW'(TOP)) begin
          fill_nxt  = {color_r, SPACE_CODE};
          state_nxt = S_FILL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (k_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
          if (init_r) begin
            init_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.cell_entry    = entry;
    out_nxt.cursor_row    = 5'(row_nxt);
    out_nxt.cursor_column = 7'(col_nxt);
    out_nxt.scrolled      = scr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      k_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      scr_r       <= 1'b0;
      init_r      <= 1'b1;
      fill_r      <= {RESET_COLOR, SPACE_CODE};
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      scr_r       <= scr_nxt;
      init_r      <= init_nxt;
      fill_r      <= fill_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE && !init_r)
    else $error("result shown while sequencer active");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) < ROWS && 32'(col_r) < COLUMNS)
    else $error("cursor out of range");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |-> out_data.cursor_row == 5'(ROWS - 1)
      && out_data.cursor_column == 7'd0)
    else $error("scroll result with cursor off the bottom line start");

  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
